### hdl/dmep_pkg.sv
// Shared types and constants of the dual motor encoder PID block.
package dmep_pkg;

   // Serial datapath widths
   localparam int unsigned ACC_W   = 48;
   localparam int unsigned MPL_W   = 16;
   localparam int unsigned STEP_W  = 6;
   localparam int unsigned REM_W   = 10;

   // Constant divisors: ms per second, and 330 pulses/rev over 60 s reduced to 11/2
   localparam logic [REM_W-1:0] INTEG_DIV = 10'd1000;
   localparam logic [REM_W-1:0] RPM_DIV   = 10'd11;

   // Register indexes
   typedef enum logic [2:0] {
      REG_KP     = 3'd0,
      REG_KD     = 3'd1,
      REG_KI     = 3'd2,
      REG_TARGET = 3'd3,
      REG_DIST   = 3'd4,
      REG_RATE   = 3'd5,
      REG_PERIOD = 3'd6,
      REG_PWM    = 3'd7
   } reg_idx_type;

   // Sequencer states
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LOAD = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_POST = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   // Which operation the serial engine is running
   typedef enum logic [2:0] {
      PH_KI   = 3'd0,
      PH_IE   = 3'd1,
      PH_IDIV = 3'd2,
      PH_KD   = 3'd3,
      PH_DR   = 3'd4,
      PH_KP   = 3'd5,
      PH_RMUL = 3'd6,
      PH_RDIV = 3'd7
   } phase_type;

endpackage

### hdl/dual_motor_encoder_pid_top.sv
// Top level of the dual motor encoder PID speed controller.
//
// Each request is an encoder edge (req_tuser = 0) or a sample tick (req_tuser = 1) and
// yields one response with both duties, speeds and distance counts. An edge goes from
// idle to ST_OUT, which hands its response to the response register once that is free. A
// tick runs the PID and rpm update for each motor in turn on one bit-serial engine
// (shift-add multiply, restoring divide by constant) before it reaches ST_OUT; the
// 48-step divides dominate. A response that is not taken holds the sequencer before its
// hand-off and so stalls the next request.
// One request is handled at a time; req_tready is high only while the sequencer is idle.
// Configuration registers are written through csr_* and must only change while idle.
module dual_motor_encoder_pid_top #(
   parameter int MOTOR_COUNT = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [0] motor, [1] direction_level, rest zero
   input  logic         req_tuser,   // [0] kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // duty_first, duty_second, rpm_first, rpm_second,
                                     // distance_first, distance_second (low to high)
   output logic         rsp_tuser,   // [0] tick_done
   input  logic         csr_wen,
   input  logic [2:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   localparam int MW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam int AW = dmep_pkg::ACC_W;

   // Configuration registers
   logic [7:0]  kp_ff, kd_ff, ki_ff;
   logic [15:0] target_ff, pwm_ff;
   logic        dist_en_ff;
   logic [13:0] rate_ff;
   logic [9:0]  period_ff;

   // Per-motor state
   logic signed [15:0] pulse_ff [MOTOR_COUNT], pulse_in [MOTOR_COUNT];
   logic signed [17:0] prev_ff  [MOTOR_COUNT], prev_in  [MOTOR_COUNT];
   logic signed [31:0] isum_ff  [MOTOR_COUNT], isum_in  [MOTOR_COUNT];
   logic [15:0]        duty_ff  [MOTOR_COUNT], duty_in  [MOTOR_COUNT];
   logic signed [31:0] rpm_ff   [MOTOR_COUNT], rpm_in   [MOTOR_COUNT];
   logic [31:0]        dist_ff  [MOTOR_COUNT], dist_in  [MOTOR_COUNT];

   // Sequencer and serial engine
   dmep_pkg::state_type state_ff, state_in;
   dmep_pkg::phase_type phase_ff, phase_in;
   logic [MW-1:0]                 m_ff, m_in;
   logic [dmep_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [AW-1:0]                 mcand_ff, mcand_in;
   logic [dmep_pkg::MPL_W-1:0]    mplier_ff, mplier_in;
   logic [AW-1:0]                 prod_ff, prod_in;
   logic [dmep_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic signed [17:0]            err_ff, err_in;
   logic signed [AW-1:0]          sum_ff, sum_in;
   logic                          kind_ff, kind_in;

   // Response register
   logic         rsp_valid_ff, rsp_valid_in;
   logic [159:0] rsp_data_ff, rsp_data_in;
   logic         rsp_user_ff, rsp_user_in;

   // Working signals
   logic [MW-1:0]         idx;
   logic signed [15:0]    cur_cnt;
   logic [16:0]           cnt_mag;
   logic [15:0]           err_abs;
   logic signed [18:0]    diff;
   logic [16:0]           diff_abs;
   logic signed [AW:0]    prod_s, q_int;
   logic signed [AW+1:0]  isum_wide;
   logic signed [31:0]    isum_new;
   logic signed [AW-1:0]  term, dsum, pwm_s, duty_c;
   logic [dmep_pkg::REM_W:0] rem_sh, dv;
   logic                  ge;
   logic [15:0] o_duty [2];
   logic [31:0] o_rpm  [2];
   logic [31:0] o_dist [2];

   assign req_tready = (state_ff == dmep_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Output view of motors 0 and 1; absent motors read as zero
   for (genvar k = 0; k < 2; k++) begin : g_out
      if (k < MOTOR_COUNT) begin : g_has
         assign o_duty[k] = duty_ff[k];
         assign o_rpm[k]  = rpm_ff[k];
         assign o_dist[k] = dist_ff[k];
      end else begin : g_none
         assign o_duty[k] = '0;
         assign o_rpm[k]  = '0;
         assign o_dist[k] = '0;
      end
   end

   // Next-state logic
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      m_in      = m_ff;
      step_in   = step_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      err_in    = err_ff;
      sum_in    = sum_ff;
      kind_in   = kind_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      pulse_in = pulse_ff;
      prev_in  = prev_ff;
      isum_in  = isum_ff;
      duty_in  = duty_ff;
      rpm_in   = rpm_ff;
      dist_in  = dist_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // One shared index into the motor state
      idx     = (state_ff == dmep_pkg::ST_IDLE) ? MW'(req_tdata[0]) : m_ff;
      cur_cnt = pulse_ff[idx];
      cnt_mag = cur_cnt[15] ? (17'd0 - {1'b1, cur_cnt}) : {1'b0, cur_cnt};
      err_abs = err_ff[17] ? 16'(18'sd0 - err_ff) : err_ff[15:0];
      diff    = {err_ff[17], err_ff} - {prev_ff[idx][17], prev_ff[idx]};
      diff_abs = diff[18] ? 17'(19'sd0 - diff) : diff[16:0];

      // Signed views of the engine result
      prod_s    = $signed({1'b0, prod_ff});
      q_int     = err_ff[17] ? -prod_s : prod_s;
      isum_wide = $signed({{18{isum_ff[idx][31]}}, isum_ff[idx]}) + $signed({q_int[AW], q_int});
      if (isum_wide > $signed(50'sh7FFFFFFF)) begin
         isum_new = 32'sh7FFFFFFF;
      end else if (isum_wide < -$signed(50'sh80000000)) begin
         isum_new = -32'sh7FFFFFFF - 32'sd1;
      end else begin
         isum_new = isum_wide[31:0];
      end
      term  = $signed(prod_ff);
      dsum  = err_ff[17] ? (sum_ff - term) : (sum_ff + term);
      pwm_s = $signed({32'd0, pwm_ff});
      duty_c = (dsum >= pwm_s) ? (pwm_s - 48'sd1) : dsum;
      if (duty_c <= 48'sd0) begin
         duty_c = 48'sd1;
      end

      // Restoring divide step
      dv     = (phase_ff == dmep_pkg::PH_IDIV) ? {1'b0, dmep_pkg::INTEG_DIV}
                                              : {1'b0, dmep_pkg::RPM_DIV};
      rem_sh = {rem_ff, prod_ff[AW-1]};
      ge     = (rem_sh >= dv);

      case (state_ff)
         dmep_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               if (req_tuser) begin
                  m_in     = '0;
                  state_in = dmep_pkg::ST_LOAD;
               end else begin
                  // Encoder edge: saturating count, optional wrapping distance
                  if (int'(req_tdata[0]) < MOTOR_COUNT) begin
                     if (req_tdata[1]) begin
                        if (cur_cnt != 16'sh7FFF) pulse_in[idx] = cur_cnt + 16'sd1;
                     end else begin
                        if (cur_cnt != -16'sh7FFF - 16'sd1) pulse_in[idx] = cur_cnt - 16'sd1;
                     end
                     if (dist_en_ff) dist_in[idx] = dist_ff[idx] + 32'd1;
                  end
                  state_in = dmep_pkg::ST_OUT;
               end
            end
         end
         dmep_pkg::ST_LOAD: begin
            err_in    = $signed({2'b00, target_ff}) - $signed({1'b0, cnt_mag});
            mcand_in  = AW'(period_ff);
            mplier_in = dmep_pkg::MPL_W'(ki_ff);
            prod_in   = '0;
            step_in   = dmep_pkg::STEP_W'(8);
            phase_in  = dmep_pkg::PH_KI;
            state_in  = dmep_pkg::ST_MUL;
         end
         // Shift-add multiply, one multiplier bit per cycle
         dmep_pkg::ST_MUL: begin
            if (mplier_ff[0]) prod_in = prod_ff + mcand_ff;
            mcand_in  = {mcand_ff[AW-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[dmep_pkg::MPL_W-1:1]};
            step_in   = step_ff - 1'b1;
            if (step_ff == dmep_pkg::STEP_W'(1)) state_in = dmep_pkg::ST_POST;
         end
         // Restoring divide, one quotient bit per cycle
         dmep_pkg::ST_DIV: begin
            rem_in  = ge ? dmep_pkg::REM_W'(rem_sh - dv) : rem_sh[dmep_pkg::REM_W-1:0];
            prod_in = {prod_ff[AW-2:0], ge};
            step_in = step_ff - 1'b1;
            if (step_ff == dmep_pkg::STEP_W'(1)) state_in = dmep_pkg::ST_POST;
         end
         dmep_pkg::ST_POST: begin
            case (phase_ff)
               dmep_pkg::PH_KI: begin
                  mcand_in  = prod_ff;
                  mplier_in = err_abs;
                  prod_in   = '0;
                  step_in   = dmep_pkg::STEP_W'(16);
                  phase_in  = dmep_pkg::PH_IE;
                  state_in  = dmep_pkg::ST_MUL;
               end
               dmep_pkg::PH_IE: begin
                  rem_in   = '0;
                  step_in  = dmep_pkg::STEP_W'(AW);
                  phase_in = dmep_pkg::PH_IDIV;
                  state_in = dmep_pkg::ST_DIV;
               end
               dmep_pkg::PH_IDIV: begin
                  isum_in[idx] = isum_new;
                  sum_in    = $signed({32'd0, duty_ff[idx]}) + AW'(isum_new);
                  mcand_in  = AW'(diff_abs);
                  mplier_in = dmep_pkg::MPL_W'(kd_ff);
                  prod_in   = '0;
                  step_in   = dmep_pkg::STEP_W'(8);
                  phase_in  = dmep_pkg::PH_KD;
                  state_in  = dmep_pkg::ST_MUL;
               end
               dmep_pkg::PH_KD: begin
                  mcand_in  = prod_ff;
                  mplier_in = dmep_pkg::MPL_W'(rate_ff);
                  prod_in   = '0;
                  step_in   = dmep_pkg::STEP_W'(14);
                  phase_in  = dmep_pkg::PH_DR;
                  state_in  = dmep_pkg::ST_MUL;
               end
               dmep_pkg::PH_DR: begin
                  sum_in    = diff[18] ? (sum_ff - term) : (sum_ff + term);
                  mcand_in  = AW'(err_abs);
                  mplier_in = dmep_pkg::MPL_W'(kp_ff);
                  prod_in   = '0;
                  step_in   = dmep_pkg::STEP_W'(8);
                  phase_in  = dmep_pkg::PH_KP;
                  state_in  = dmep_pkg::ST_MUL;
               end
               dmep_pkg::PH_KP: begin
                  duty_in[idx] = duty_c[15:0];
                  prev_in[idx] = err_ff;
                  mcand_in  = AW'(cnt_mag);
                  mplier_in = dmep_pkg::MPL_W'(rate_ff);
                  prod_in   = '0;
                  step_in   = dmep_pkg::STEP_W'(14);
                  phase_in  = dmep_pkg::PH_RMUL;
                  state_in  = dmep_pkg::ST_MUL;
               end
               dmep_pkg::PH_RMUL: begin
                  prod_in  = {prod_ff[AW-2:0], 1'b0};
                  rem_in   = '0;
                  step_in  = dmep_pkg::STEP_W'(AW);
                  phase_in = dmep_pkg::PH_RDIV;
                  state_in = dmep_pkg::ST_DIV;
               end
               dmep_pkg::PH_RDIV: begin
                  rpm_in[idx]   = cur_cnt[15] ? (32'sd0 - $signed(prod_ff[31:0]))
                                              : $signed(prod_ff[31:0]);
                  pulse_in[idx] = '0;
                  if (int'(m_ff) == MOTOR_COUNT - 1) begin
                     state_in = dmep_pkg::ST_OUT;
                  end else begin
                     m_in     = m_ff + 1'b1;
                     state_in = dmep_pkg::ST_LOAD;
                  end
               end
               default: state_in = dmep_pkg::ST_IDLE;
            endcase
         end
         // Hand the snapshot to the response register once it is free
         dmep_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = kind_ff;
               rsp_data_in  = {o_dist[1], o_dist[0], o_rpm[1], o_rpm[0], o_duty[1], o_duty[0]};
               state_in     = dmep_pkg::ST_IDLE;
            end
         end
         default: state_in = dmep_pkg::ST_IDLE;
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dmep_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            pulse_ff[i] <= '0;
            prev_ff[i]  <= '0;
            isum_ff[i]  <= '0;
            duty_ff[i]  <= '0;
            rpm_ff[i]   <= '0;
            dist_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pulse_ff <= pulse_in;
         prev_ff  <= prev_in;
         isum_ff  <= isum_in;
         duty_ff  <= duty_in;
         rpm_ff   <= rpm_in;
         dist_ff  <= dist_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      phase_ff    <= phase_in;
      m_ff        <= m_in;
      step_ff     <= step_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      err_ff      <= err_in;
      sum_ff      <= sum_in;
      kind_ff     <= kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff      <= 8'd20;
         kd_ff      <= 8'd5;
         ki_ff      <= 8'd0;
         target_ff  <= 16'd0;
         dist_en_ff <= 1'b0;
         rate_ff    <= 14'd100;
         period_ff  <= 10'd10;
         pwm_ff     <= 16'd1000;
      end else if (csr_wen) begin
         case (dmep_pkg::reg_idx_type'(csr_addr))
            dmep_pkg::REG_KP:     kp_ff      <= csr_wdata[7:0];
            dmep_pkg::REG_KD:     kd_ff      <= csr_wdata[7:0];
            dmep_pkg::REG_KI:     ki_ff      <= csr_wdata[7:0];
            dmep_pkg::REG_TARGET: target_ff  <= csr_wdata;
            dmep_pkg::REG_DIST:   dist_en_ff <= csr_wdata[0];
            dmep_pkg::REG_RATE:   rate_ff    <= csr_wdata[13:0];
            dmep_pkg::REG_PERIOD: period_ff  <= csr_wdata[9:0];
            dmep_pkg::REG_PWM:    pwm_ff     <= csr_wdata;
            default:              kp_ff      <= kp_ff;
         endcase
      end
   end

endmodule
